// File: design/generational_slot_table_core_defines.svh
// Assertion macros for the generational slot table core.
`ifndef GENERATIONAL_SLOT_TABLE_CORE_DEFINES_SVH
`define GENERATIONAL_SLOT_TABLE_CORE_DEFINES_SVH

// Same-cycle implication, clocked on clock, off during reset.
`define GST_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, clocked on clock, off during reset.
`define GST_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// File: design/gst_pkg.sv
// Types and constants shared by the generational slot table core.
package gst_pkg;

   localparam int SLOTS     = 256;
   localparam int GEN_BITS  = 16;
   localparam int TYPE_BITS = 8;
   localparam int SLOT_BITS = $clog2(SLOTS);
   localparam int LIVE_BITS = SLOT_BITS + 1;

   localparam int KIND_BITS      = 3;
   localparam int HANDLE_BITS    = 11;
   localparam int HGEN_BITS      = 16;
   localparam int TAG_BITS       = 8;
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 11;
   localparam int RESERVED_BITS  = 9;
   localparam int DYNAMIC_BITS   = 9;

   localparam logic [HANDLE_BITS-1:0]   STATIC_RESET   = '0;
   localparam logic [RESERVED_BITS-1:0] RESERVED_RESET = '0;
   localparam logic [DYNAMIC_BITS-1:0]  DYNAMIC_RESET  = 9'd256;

   typedef enum logic [KIND_BITS-1:0] {
      KIND_ALLOC_FIRST = 3'd0,
      KIND_ALLOC_AT    = 3'd1,
      KIND_FREE        = 3'd2,
      KIND_RESOLVE     = 3'd3,
      KIND_QUERY       = 3'd4,
      KIND_CLEAR       = 3'd5
   } kind_type;

   typedef enum logic [1:0] {
      STATUS_OK    = 2'd0,
      STATUS_MISS  = 2'd1,
      STATUS_ERROR = 2'd2
   } status_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_STATIC_COUNT   = 2'd0,
      CSR_RESERVED_SLOTS = 2'd1,
      CSR_DYNAMIC_SLOTS  = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [KIND_BITS-1:0]   kind;
      logic [HANDLE_BITS-1:0] slot_id;
      logic [HGEN_BITS-1:0]   handle_gen;
      logic [TAG_BITS-1:0]    type_tag;
   } req_type;

   typedef struct packed {
      status_type             status;
      logic [HANDLE_BITS-1:0] handle_slot;
      logic [HGEN_BITS-1:0]   handle_gen_out;
      logic [TAG_BITS-1:0]    type_out;
   } rsp_type;

endpackage

// File: design/gst_ram.sv
// Generic single-port-write, registered-read RAM.
module gst_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/generational_slot_table_core.sv
// Top level of the generational slot table: command sequencer, slot stores, registers.
// Alloc-at, free, dynamic resolve and query go through decode, RAM read and execute;
// static resolve, clear, range failures and unknown kinds are answered at decode.
// Alloc-first-free walks one slot per cycle from reserved_slots, then reads and executes;
// a full table ends in a miss. One request at a time; busy drops in the response cycle.
// Synchronous reset clears used bits and generations at once; no clearing pass.
`include "generational_slot_table_core_defines.svh"

module generational_slot_table_core import gst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  req_type                   req_cmd,
   output logic                      busy,
   output logic                      rsp_valid,
   output rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data
);

   typedef enum logic [4:0] {
      ST_IDLE   = 5'b00001,
      ST_DECODE = 5'b00010,
      ST_SCAN   = 5'b00100,
      ST_READ   = 5'b01000,
      ST_EXEC   = 5'b10000
   } state_type;

   state_type                state_ff, state_in;
   req_type                  cmd_ff, cmd_in;
   logic [LIVE_BITS-1:0]     slot_ff, slot_in;
   logic [SLOTS-1:0]         used_ff, used_in;
   logic [SLOTS-1:0]         gen_valid_ff, gen_valid_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   rsp_type                  rsp_data_ff, rsp_data_in;
   logic [HANDLE_BITS-1:0]   static_count_ff;
   logic [RESERVED_BITS-1:0] reserved_ff;
   logic [DYNAMIC_BITS-1:0]  dynamic_ff;

   logic [LIVE_BITS-1:0]   live_n;
   logic [SLOT_BITS-1:0]   slot_idx;
   logic [LIVE_BITS-1:0]   scan_next;
   logic [HANDLE_BITS-1:0] sid_dyn;
   logic [HANDLE_BITS-1:0] handle_dyn;
   logic                   sid_static;
   logic                   sid_in_live;
   logic                   dyn_in_live;
   logic                   gen_wr_en;
   logic                   type_wr_en;
   logic                   rd_en;
   logic [GEN_BITS-1:0]    gen_rd;
   logic [GEN_BITS-1:0]    gen_cur;
   logic [GEN_BITS-1:0]    gen_inc;
   logic [TYPE_BITS-1:0]   type_rd;
   logic [TYPE_BITS-1:0]   tag;
   logic                   gen_match;
   logic                   type_match;

   function automatic rsp_type pack_rsp(status_type st, logic [HANDLE_BITS-1:0] hs,
                                        logic [GEN_BITS-1:0] g, logic [TYPE_BITS-1:0] t);
      rsp_type r;
      r.status         = st;
      r.handle_slot    = '0;
      r.handle_gen_out = '0;
      r.type_out       = '0;
      if (st == STATUS_OK) begin
         r.handle_slot    = hs;
         r.handle_gen_out = HGEN_BITS'(g);
         r.type_out       = TAG_BITS'(t);
      end
      return r;
   endfunction

   assign live_n      = (32'(dynamic_ff) < 32'(SLOTS)) ? LIVE_BITS'(dynamic_ff)
                                                       : LIVE_BITS'(SLOTS);
   assign slot_idx    = slot_ff[SLOT_BITS-1:0];
   assign scan_next   = slot_ff + LIVE_BITS'(1);
   assign sid_static  = cmd_ff.slot_id < static_count_ff;
   assign sid_dyn     = cmd_ff.slot_id - static_count_ff;
   assign sid_in_live = 32'(cmd_ff.slot_id) < 32'(live_n);
   assign dyn_in_live = 32'(sid_dyn) < 32'(live_n);
   assign handle_dyn  = static_count_ff + HANDLE_BITS'(slot_ff);
   assign gen_cur     = gen_valid_ff[slot_idx] ? gen_rd : '0;
   assign gen_inc     = gen_cur + GEN_BITS'(1);
   assign tag         = TYPE_BITS'(cmd_ff.type_tag);
   assign gen_match   = 32'(gen_cur) == 32'(cmd_ff.handle_gen);
   assign type_match  = type_rd == tag;
   assign rd_en       = state_ff == ST_READ;

   gst_ram #(.WIDTH(GEN_BITS), .DEPTH(SLOTS)) u_gen_ram (
      .clock   (clock),
      .wr_en   (gen_wr_en),
      .wr_addr (slot_idx),
      .wr_data (gen_inc),
      .rd_en   (rd_en),
      .rd_addr (slot_idx),
      .rd_data (gen_rd)
   );

   gst_ram #(.WIDTH(TYPE_BITS), .DEPTH(SLOTS)) u_type_ram (
      .clock   (clock),
      .wr_en   (type_wr_en),
      .wr_addr (slot_idx),
      .wr_data (tag),
      .rd_en   (rd_en),
      .rd_addr (slot_idx),
      .rd_data (type_rd)
   );

   always_comb begin
      state_in     = state_ff;
      cmd_in       = cmd_ff;
      slot_in      = slot_ff;
      used_in      = used_ff;
      gen_valid_in = gen_valid_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = rsp_data_ff;
      gen_wr_en    = 1'b0;
      type_wr_en   = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               cmd_in   = req_cmd;
               state_in = ST_DECODE;
            end
         end
         ST_DECODE: begin
            state_in     = ST_READ;
            rsp_data_in  = pack_rsp(STATUS_ERROR, '0, '0, '0);
            unique case (cmd_ff.kind)
               KIND_ALLOC_FIRST: begin
                  if (32'(reserved_ff) >= 32'(live_n)) begin
                     rsp_data_in  = pack_rsp(STATUS_MISS, '0, '0, '0);
                     rsp_valid_in = 1'b1;
                  end else begin
                     slot_in  = LIVE_BITS'(reserved_ff);
                     state_in = ST_SCAN;
                  end
               end
               KIND_ALLOC_AT: begin
                  if (!sid_in_live) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     slot_in = LIVE_BITS'(cmd_ff.slot_id);
                  end
               end
               KIND_FREE: begin
                  if (sid_static || !dyn_in_live) begin
                     rsp_valid_in = 1'b1;
                  end else begin
                     slot_in = LIVE_BITS'(sid_dyn);
                  end
               end
               KIND_RESOLVE: begin
                  if (sid_static) begin
                     rsp_valid_in = 1'b1;
                     if (cmd_ff.handle_gen != '0) begin
                        rsp_data_in = pack_rsp(STATUS_MISS, '0, '0, '0);
                     end else begin
                        rsp_data_in = pack_rsp(STATUS_OK, cmd_ff.slot_id, '0, '0);
                     end
                  end else if (!dyn_in_live) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(STATUS_MISS, '0, '0, '0);
                  end else begin
                     slot_in = LIVE_BITS'(sid_dyn);
                  end
               end
               KIND_QUERY: begin
                  if (32'(cmd_ff.slot_id) >= 32'(reserved_ff) || !sid_in_live) begin
                     rsp_valid_in = 1'b1;
                     rsp_data_in  = pack_rsp(STATUS_MISS, '0, '0, '0);
                  end else begin
                     slot_in = LIVE_BITS'(cmd_ff.slot_id);
                  end
               end
               KIND_CLEAR: begin
                  gen_valid_in = '0;
                  rsp_valid_in = 1'b1;
                  rsp_data_in  = pack_rsp(STATUS_OK, '0, '0, '0);
               end
               default: begin
                  rsp_valid_in = 1'b1;
               end
            endcase
            if (rsp_valid_in) begin
               state_in = ST_IDLE;
            end
         end
         ST_SCAN: begin
            if (!used_ff[slot_idx]) begin
               state_in = ST_READ;
            end else if (32'(scan_next) >= 32'(live_n)) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = pack_rsp(STATUS_MISS, '0, '0, '0);
               state_in     = ST_IDLE;
            end else begin
               slot_in = scan_next;
            end
         end
         ST_READ: begin
            state_in = ST_EXEC;
         end
         ST_EXEC: begin
            state_in     = ST_IDLE;
            rsp_valid_in = 1'b1;
            unique case (cmd_ff.kind) inside
               KIND_ALLOC_FIRST, KIND_ALLOC_AT: begin
                  used_in[slot_idx] = 1'b1;
                  type_wr_en        = 1'b1;
                  rsp_data_in       = pack_rsp(STATUS_OK, handle_dyn, gen_cur, tag);
               end
               KIND_FREE: begin
                  if (!used_ff[slot_idx]) begin
                     rsp_data_in = pack_rsp(STATUS_ERROR, '0, '0, '0);
                  end else begin
                     used_in[slot_idx]      = 1'b0;
                     gen_valid_in[slot_idx] = 1'b1;
                     gen_wr_en              = 1'b1;
                     rsp_data_in = pack_rsp(STATUS_OK, cmd_ff.slot_id, gen_inc, type_rd);
                  end
               end
               KIND_RESOLVE: begin
                  if (used_ff[slot_idx] && gen_match) begin
                     rsp_data_in = pack_rsp(STATUS_OK, handle_dyn, gen_cur, type_rd);
                  end else begin
                     rsp_data_in = pack_rsp(STATUS_MISS, '0, '0, '0);
                  end
               end
               KIND_QUERY: begin
                  if (used_ff[slot_idx] && type_match) begin
                     rsp_data_in = pack_rsp(STATUS_OK, handle_dyn, gen_cur, type_rd);
                  end else begin
                     rsp_data_in = pack_rsp(STATUS_MISS, '0, '0, '0);
                  end
               end
               default: begin
                  rsp_data_in = pack_rsp(STATUS_ERROR, '0, '0, '0);
               end
            endcase
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         used_ff         <= '0;
         gen_valid_ff    <= '0;
         rsp_valid_ff    <= 1'b0;
         static_count_ff <= STATIC_RESET;
         reserved_ff     <= RESERVED_RESET;
         dynamic_ff      <= DYNAMIC_RESET;
      end else begin
         state_ff     <= state_in;
         used_ff      <= used_in;
         gen_valid_ff <= gen_valid_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               CSR_STATIC_COUNT:   static_count_ff <= csr_wr_data;
               CSR_RESERVED_SLOTS: reserved_ff     <= csr_wr_data[RESERVED_BITS-1:0];
               CSR_DYNAMIC_SLOTS:  dynamic_ff      <= csr_wr_data[DYNAMIC_BITS-1:0];
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff      <= cmd_in;
      slot_ff     <= slot_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = state_ff != ST_IDLE;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   `GST_ASSERT_IMP(a_rsp_when_idle, rsp_valid_ff, state_ff == ST_IDLE, "response while busy")
   `GST_ASSERT_NXT(a_accept_decode, start && !busy, state_ff == ST_DECODE, "request not decoded")
   `GST_ASSERT_IMP(a_scan_in_range, state_ff == ST_SCAN, 32'(slot_ff) < 32'(live_n), "scan overrun")
   `GST_ASSERT_NXT(a_alloc_marks_used, state_ff == ST_EXEC && (cmd_ff.kind == KIND_ALLOC_FIRST || cmd_ff.kind == KIND_ALLOC_AT), used_ff[$past(slot_idx)], "alloc left slot free")
   `GST_ASSERT_NXT(a_clear_gens, state_ff == ST_DECODE && cmd_ff.kind == KIND_CLEAR, gen_valid_ff == '0, "generations not cleared")

endmodule

// File: test/generational_slot_table_core_checker.sv
`timescale 1ns / 1ps
// Checker for the slot table core: tracks the table, predicts each response, compares.
module generational_slot_table_core_checker import gst_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   input  logic                      busy,
   input  req_type                   req_cmd,
   input  logic                      rsp_valid,
   input  rsp_type                   rsp_data,
   input  logic                      csr_wr_en,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wr_data,
   output int                        mismatches,
   output int                        outstanding,
   output int                        checked
);

   logic                     slot_used [SLOTS];
   logic [GEN_BITS-1:0]      slot_gen [SLOTS];
   logic [TYPE_BITS-1:0]     slot_tag [SLOTS];
   logic [HANDLE_BITS-1:0]   static_count;
   logic [RESERVED_BITS-1:0] reserved_slots;
   logic [DYNAMIC_BITS-1:0]  dynamic_slots;
   rsp_type                  due_responses [$];
   rsp_type                  expected_rsp;

   initial begin
      mismatches  = 0;
      outstanding = 0;
      checked     = 0;
   end

   function automatic rsp_type slot_answer(int d);
      rsp_type r;
      r                = '0;
      r.status         = STATUS_OK;
      r.handle_slot    = HANDLE_BITS'(int'(static_count) + d);
      r.handle_gen_out = HGEN_BITS'(slot_gen[d]);
      r.type_out       = TAG_BITS'(slot_tag[d]);
      return r;
   endfunction

   function automatic rsp_type apply_command(req_type c);
      rsp_type r;
      int      live;
      int      sid;
      int      d;
      logic    found;
      r        = '0;
      r.status = STATUS_ERROR;
      found    = 1'b0;
      live     = (int'(dynamic_slots) < SLOTS) ? int'(dynamic_slots) : SLOTS;
      sid      = int'(c.slot_id);
      case (c.kind)
         KIND_ALLOC_FIRST: begin
            r.status = STATUS_MISS;
            for (int i = int'(reserved_slots); i < live; i++) begin
               if (!found && !slot_used[i]) begin
                  found       = 1'b1;
                  slot_used[i] = 1'b1;
                  slot_tag[i]  = c.type_tag;
                  r            = slot_answer(i);
               end
            end
         end
         KIND_ALLOC_AT: begin
            if (sid < live) begin
               slot_used[sid] = 1'b1;
               slot_tag[sid]  = c.type_tag;
               r              = slot_answer(sid);
            end
         end
         KIND_FREE: begin
            if (sid >= int'(static_count)) begin
               d = sid - int'(static_count);
               if (d < live) begin
                  if (slot_used[d]) begin
                     slot_gen[d]  = slot_gen[d] + 1'b1;
                     slot_used[d] = 1'b0;
                     r            = slot_answer(d);
                  end
               end
            end
         end
         KIND_RESOLVE: begin
            r.status = STATUS_MISS;
            if (sid < int'(static_count)) begin
               if (c.handle_gen == '0) begin
                  r.status      = STATUS_OK;
                  r.handle_slot = c.slot_id;
               end
            end else begin
               d = sid - int'(static_count);
               if (d < live) begin
                  if (slot_used[d] && slot_gen[d] == c.handle_gen)
                     r = slot_answer(d);
               end
            end
         end
         KIND_QUERY: begin
            r.status = STATUS_MISS;
            if (sid < int'(reserved_slots) && sid < live) begin
               if (slot_used[sid] && slot_tag[sid] == c.type_tag)
                  r = slot_answer(sid);
            end
         end
         KIND_CLEAR: begin
            for (int i = 0; i < SLOTS; i++)
               slot_gen[i] = '0;
            r.status = STATUS_OK;
         end
         default: ;
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            slot_used[i] = 1'b0;
            slot_gen[i]  = '0;
            slot_tag[i]  = '0;
         end
         static_count   = STATIC_RESET;
         reserved_slots = RESERVED_RESET;
         dynamic_slots  = DYNAMIC_RESET;
         due_responses.delete();
         outstanding = 0;
      end else begin
         if (csr_wr_en) begin
            case (csr_index)
               CSR_STATIC_COUNT:   static_count   = csr_wr_data;
               CSR_RESERVED_SLOTS: reserved_slots = csr_wr_data[RESERVED_BITS-1:0];
               CSR_DYNAMIC_SLOTS:  dynamic_slots  = csr_wr_data[DYNAMIC_BITS-1:0];
               default: ;
            endcase
         end
         if (rsp_valid) begin
            if (due_responses.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: response with no request pending: status %0d slot %0d gen %0d type %0d",
                     $realtime, rsp_data.status, rsp_data.handle_slot,
                     rsp_data.handle_gen_out, rsp_data.type_out);
            end else begin
               expected_rsp = due_responses.pop_front();
               checked++;
               if (rsp_data.status !== expected_rsp.status ||
                   rsp_data.handle_slot !== expected_rsp.handle_slot ||
                   rsp_data.handle_gen_out !== expected_rsp.handle_gen_out ||
                   rsp_data.type_out !== expected_rsp.type_out) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch, expected status %0d slot %0d gen %0d type %0d, got status %0d slot %0d gen %0d type %0d",
                        $realtime, expected_rsp.status, expected_rsp.handle_slot,
                        expected_rsp.handle_gen_out, expected_rsp.type_out,
                        rsp_data.status, rsp_data.handle_slot,
                        rsp_data.handle_gen_out, rsp_data.type_out);
               end
            end
         end
         if (start && !busy)
            due_responses.push_back(apply_command(req_cmd));
         outstanding = due_responses.size();
      end
   end

endmodule

// File: test/generational_slot_table_core_tb.sv
`timescale 1ns / 1ps
// Testbench top for the slot table core: stimulus, register settings and verdict.
module generational_slot_table_core_tb;
   import gst_pkg::*;

   localparam logic [KIND_BITS-1:0] KIND_SPARE_LO = 3'd6;
   localparam logic [KIND_BITS-1:0] KIND_SPARE_HI = 3'd7;

   typedef struct {
      logic [HANDLE_BITS-1:0] slot;
      logic [HGEN_BITS-1:0]   gen;
      logic [TAG_BITS-1:0]    tag;
   } handle_type;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      start       = 1'b0;
   req_type                   req_cmd     = '0;
   logic                      busy;
   logic                      rsp_valid;
   rsp_type                   rsp_data;
   logic                      csr_wr_en   = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index   = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wr_data = '0;

   int mismatches;
   int outstanding;
   int checked;

   handle_type live_handles [$];
   int         cur_static;
   int         cur_reserved;
   int         cur_live;
   int         settings_used = 0;
   int         issued = 0;

   generational_slot_table_core i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .req_cmd     (req_cmd),
      .busy        (busy),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data)
   );

   generational_slot_table_core_checker i_checker (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_cmd     (req_cmd),
      .rsp_valid   (rsp_valid),
      .rsp_data    (rsp_data),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wr_data (csr_wr_data),
      .mismatches  (mismatches),
      .outstanding (outstanding),
      .checked     (checked)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // handles handed back by the block feed later frees, resolves and queries
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_data.status == STATUS_OK) begin
         live_handles.push_back('{rsp_data.handle_slot, rsp_data.handle_gen_out,
                                  rsp_data.type_out});
         if (live_handles.size() > 32)
            void'(live_handles.pop_front());
      end
   end

   function automatic req_type command(logic [KIND_BITS-1:0] k, int sid, int g, int t);
      req_type c;
      c.kind       = k;
      c.slot_id    = HANDLE_BITS'(sid);
      c.handle_gen = HGEN_BITS'(g);
      c.type_tag   = TAG_BITS'(t);
      return c;
   endfunction

   task automatic send(req_type c);
      @(negedge clock);
      start   <= 1'b1;
      req_cmd <= c;
      while (busy)
         @(negedge clock);
      @(posedge clock);
      issued++;
   endtask

   task automatic pause_sender(int n);
      @(negedge clock);
      start <= 1'b0;
      repeat (n) @(negedge clock);
   endtask

   task automatic settle();
      pause_sender(0);
      while (outstanding != 0)
         @(negedge clock);
      repeat (4) @(negedge clock);
   endtask

   task automatic configure(int s, int r, int dyn);
      settle();
      @(negedge clock);
      csr_wr_en   <= 1'b1;
      csr_index   <= CSR_STATIC_COUNT;
      csr_wr_data <= CSR_DATA_BITS'(s);
      @(negedge clock);
      csr_index   <= CSR_RESERVED_SLOTS;
      csr_wr_data <= CSR_DATA_BITS'(r);
      @(negedge clock);
      csr_index   <= CSR_DYNAMIC_SLOTS;
      csr_wr_data <= CSR_DATA_BITS'(dyn);
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_static   = s % 2048;
      cur_reserved = r % 512;
      cur_live     = (dyn % 512 < SLOTS) ? dyn % 512 : SLOTS;
      settings_used++;
   endtask

   function automatic int pick_slot();
      if (cur_live == 0)
         return $urandom_range(3);
      if ($urandom_range(9) == 0)
         return $urandom_range(cur_live + 4, cur_live);
      return $urandom_range(cur_live - 1);
   endfunction

   function automatic req_type random_command();
      handle_type h;
      int         r;
      bit         use_pool;
      r        = $urandom_range(99);
      use_pool = live_handles.size() != 0 && $urandom_range(9) < 7;
      if (live_handles.size() != 0)
         h = live_handles[$urandom_range(live_handles.size() - 1)];
      if (r < 22)
         return command(KIND_ALLOC_FIRST, $urandom, $urandom, $urandom);
      if (r < 32)
         return command(KIND_ALLOC_AT, pick_slot(), $urandom, $urandom);
      if (r < 52) begin
         if (use_pool)
            return command(KIND_FREE, h.slot, $urandom, $urandom);
         if (cur_static != 0 && $urandom_range(3) == 0)
            return command(KIND_FREE, $urandom_range(cur_static - 1), $urandom, $urandom);
         return command(KIND_FREE, cur_static + pick_slot(), $urandom, $urandom);
      end
      if (r < 76) begin
         if (use_pool)
            return command(KIND_RESOLVE, h.slot,
                           ($urandom_range(4) == 0) ? h.gen + 1 : h.gen, $urandom);
         if (cur_static != 0 && $urandom_range(1) == 0)
            return command(KIND_RESOLVE, $urandom_range(cur_static - 1),
                           $urandom_range(3) == 0 ? $urandom : 0, $urandom);
         return command(KIND_RESOLVE, cur_static + pick_slot(), $urandom_range(3), $urandom);
      end
      if (r < 88) begin
         if (use_pool)
            return command(KIND_QUERY, (int'(h.slot) - cur_static) & 2047, $urandom, h.tag);
         return command(KIND_QUERY, $urandom_range(cur_reserved + 1), $urandom, $urandom);
      end
      if (r < 91)
         return command(KIND_CLEAR, $urandom, $urandom, $urandom);
      if (r < 93)
         return command($urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO,
                        $urandom, $urandom, $urandom);
      return command($urandom_range(7), $urandom, $urandom, $urandom);
   endfunction

   task automatic run_phase(int s, int r, int dyn, int n, bit gaps);
      configure(s, r, dyn);
      repeat (n) begin
         if (gaps && $urandom_range(99) < 22)
            pause_sender($urandom_range(6));
         send(random_command());
      end
   endtask

   initial begin
      #20_000_000;
      $display("generational_slot_table_core_tb failed");
      $finish;
   end

   initial begin
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      configure(4, 2, 256);
      send(command(KIND_RESOLVE, 0, 0, 0));
      send(command(KIND_RESOLVE, 3, 1, 0));
      send(command(KIND_RESOLVE, 4, 0, 0));
      send(command(KIND_ALLOC_FIRST, 0, 0, 8'hFF));
      send(command(KIND_ALLOC_FIRST, 2047, 16'hFFFF, 8'h00));
      send(command(KIND_ALLOC_AT, 0, 0, 8'hA5));
      send(command(KIND_ALLOC_AT, 255, 0, 8'h5A));
      send(command(KIND_ALLOC_AT, 256, 0, 8'h01));
      send(command(KIND_ALLOC_AT, 2047, 16'hFFFF, 8'hFF));
      send(command(KIND_RESOLVE, 6, 0, 0));
      send(command(KIND_RESOLVE, 6, 16'hFFFF, 0));
      send(command(KIND_QUERY, 0, 0, 8'hA5));
      send(command(KIND_QUERY, 0, 0, 8'hA4));
      send(command(KIND_QUERY, 2, 0, 8'hFF));
      send(command(KIND_FREE, 6, 0, 0));
      send(command(KIND_FREE, 6, 0, 0));
      send(command(KIND_FREE, 1, 0, 0));
      send(command(KIND_RESOLVE, 6, 0, 0));
      send(command(KIND_RESOLVE, 6, 1, 0));
      send(command(KIND_FREE, 259, 0, 0));
      send(command(KIND_RESOLVE, 2047, 0, 0));
      send(command(KIND_CLEAR, 0, 0, 0));
      send(command(KIND_RESOLVE, 4, 0, 0));
      send(command(KIND_SPARE_LO, 0, 0, 0));
      send(command(KIND_SPARE_HI, 2047, 16'hFFFF, 8'hFF));

      run_phase(0, 0, 256, 200, 1'b1);
      run_phase(5, 2, 8, 200, 1'b0);
      run_phase(1024, 256, 256, 120, 1'b1);
      run_phase(1900, 3, 511, 120, 1'b1);
      run_phase(0, 0, 0, 60, 1'b1);
      run_phase(12, 16, 40, 225, 1'b1);

      settle();
      repeat (16) @(negedge clock);
      $display("%0d requests over %0d register settings, %0d responses checked",
               issued, settings_used, checked);
      $display("covered: first-free and at-slot allocation, frees, resolves, reserved queries,");
      $display("generation clears, spare kinds, full and empty tables, wrapped handles");
      if (mismatches == 0 && outstanding == 0)
         $display("generational_slot_table_core_tb passed");
      else
         $display("generational_slot_table_core_tb failed");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/gst_pkg.sv
design/gst_ram.sv
design/generational_slot_table_core.sv
test/generational_slot_table_core_checker.sv
test/generational_slot_table_core_tb.sv
